[design/uct_pkg.sv]
// ----------------------------------------------------------------------------
// uct_pkg
// Shared constants, codes and types of the identifier counter table.
// ----------------------------------------------------------------------------
package uct_pkg;

   // table geometry
   localparam int ENTRIES  = 64;
   localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int LAST_IDX = ENTRIES - 1;

   // field widths
   localparam int ID_W    = 32;
   localparam int CNT_W   = 8;
   localparam int SLOT_W  = 8;
   localparam int CMD_W   = 3;
   localparam int STS_W   = 2;
   localparam int TDATA_W = 56;

   localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOOKUP  = 3'd0,
      CMD_CREATE  = 3'd1,
      CMD_INCR    = 3'd2,
      CMD_WRITE   = 3'd3,
      CMD_READ    = 3'd4,
      CMD_CLR_CNT = 3'd5,
      CMD_CLR_ALL = 3'd6,
      CMD_NOP     = 3'd7
   } uct_cmd_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK        = 2'd0,
      STS_NOT_FOUND = 2'd1,
      STS_FULL      = 2'd2,
      STS_RANGE     = 2'd3
   } uct_status_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_LOOKUP,
      S_CREATE,
      S_FETCH,
      S_CLR_CNT,
      S_DONE
   } uct_state_type;

   typedef struct packed {
      uct_cmd_type         cmd;
      logic [ID_W-1:0]     ident;
      logic [SLOT_W-1:0]   slot;
      logic [CNT_W-1:0]    count_value;
   } uct_req_type;

   typedef struct packed {
      uct_status_type      status;
      logic [SLOT_W-1:0]   result_slot;
      logic [ID_W-1:0]     entry_ident;
      logic [CNT_W-1:0]    entry_count;
      logic                entry_valid;
   } uct_rsp_type;

   typedef struct packed {
      logic                ident_we;
      logic                count_we;
      logic [IDX_W-1:0]    wr_addr;
      logic [ID_W-1:0]     ident_wdata;
      logic [CNT_W-1:0]    count_wdata;
      logic [IDX_W-1:0]    ident_raddr;
      logic [IDX_W-1:0]    count_raddr;
   } uct_mem_req_type;

endpackage

[design/uct_ram.sv]
// ----------------------------------------------------------------------------
// uct_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module uct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/uct_ctrl.sv]
// ----------------------------------------------------------------------------
// uct_ctrl
// Command sequencer: valid bits, entry scans and read-modify-write of the
// identifier and counter memories.
// ----------------------------------------------------------------------------
module uct_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  uct_pkg::uct_req_type     req,
   output logic                     req_ready,
   output uct_pkg::uct_mem_req_type mem,
   input  logic [uct_pkg::ID_W-1:0]  ident_rdata,
   input  logic [uct_pkg::CNT_W-1:0] count_rdata,
   output logic                     res_valid,
   output uct_pkg::uct_rsp_type     res,
   input  logic                     res_ready
);
   import uct_pkg::*;

   uct_state_type      state_ff, state_in;
   uct_req_type        req_ff, req_in;
   uct_rsp_type        res_ff, res_in;
   logic [IDX_W-1:0]   scan_ff, scan_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]   chk_idx_ff, chk_idx_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;

   logic               slot_ok;
   logic [IDX_W-1:0]   slot_idx;
   logic [IDX_W-1:0]   held_idx;
   logic               scan_last;
   logic               chk_last;
   logic               chk_hit;
   logic               free_here;
   logic [CNT_W-1:0]   count_next;

   // helper terms
   assign slot_ok    = {1'b0, req.slot} < (SLOT_W + 1)'(ENTRIES);
   assign slot_idx   = req.slot[IDX_W-1:0];
   assign held_idx   = req_ff.slot[IDX_W-1:0];
   assign scan_last  = scan_ff == IDX_W'(LAST_IDX);
   assign chk_last   = chk_idx_ff == IDX_W'(LAST_IDX);
   assign chk_hit    = chk_vld_ff && valid_ff[chk_idx_ff] && (ident_rdata == req_ff.ident);
   assign free_here  = !valid_ff[scan_ff];
   assign count_next = (count_rdata == COUNT_MAX) ? COUNT_MAX : count_rdata + CNT_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT: begin
            if (scan_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               case (req.cmd)
                  CMD_LOOKUP:  state_in = S_LOOKUP;
                  CMD_CREATE:  state_in = S_CREATE;
                  CMD_CLR_CNT: state_in = S_CLR_CNT;
                  CMD_INCR, CMD_READ: begin
                     state_in = slot_ok ? S_FETCH : S_DONE;
                  end
                  default:     state_in = S_DONE;
               endcase
            end
         end
         S_LOOKUP: begin
            if (chk_vld_ff && (chk_hit || chk_last)) state_in = S_DONE;
         end
         S_CREATE: begin
            if (free_here || scan_last) state_in = S_DONE;
         end
         S_FETCH:   state_in = S_DONE;
         S_CLR_CNT: begin
            if (scan_last) state_in = S_DONE;
         end
         S_DONE: begin
            if (res_ready) state_in = S_IDLE;
         end
         default:   state_in = S_IDLE;
      endcase
   end

   // outputs and datapath next values
   always_comb begin
      req_ready       = 1'b0;
      res_valid       = 1'b0;
      mem             = '0;
      mem.ident_raddr = (state_ff == S_LOOKUP) ? scan_ff : slot_idx;
      mem.count_raddr = slot_idx;
      req_in          = req_ff;
      res_in          = res_ff;
      scan_in         = scan_ff;
      chk_vld_in      = 1'b0;
      chk_idx_in      = chk_idx_ff;
      valid_in        = valid_ff;
      case (state_ff)
         S_INIT: begin
            // zero both memories after reset, one entry a cycle
            mem.ident_we = 1'b1;
            mem.count_we = 1'b1;
            mem.wr_addr  = scan_ff;
            scan_in      = scan_ff + IDX_W'(1);
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in  = req;
               scan_in = '0;
               res_in  = '0;
               case (req.cmd)
                  CMD_INCR, CMD_READ: begin
                     if (!slot_ok) res_in.status = STS_RANGE;
                  end
                  CMD_WRITE: begin
                     if (slot_ok) begin
                        mem.count_we    = 1'b1;
                        mem.wr_addr     = slot_idx;
                        mem.count_wdata = req.count_value;
                     end else begin
                        res_in.status = STS_RANGE;
                     end
                  end
                  CMD_CLR_ALL: valid_in = '0;
                  default: ;
               endcase
            end
         end
         S_LOOKUP: begin
            // read one entry a cycle, compare it the cycle after
            scan_in    = scan_ff + IDX_W'(1);
            chk_vld_in = 1'b1;
            chk_idx_in = scan_ff;
            if (chk_hit) begin
               res_in.result_slot = SLOT_W'(chk_idx_ff);
            end else if (chk_vld_ff && chk_last) begin
               res_in.status = STS_NOT_FOUND;
            end
         end
         S_CREATE: begin
            // first free slot takes the new entry
            scan_in = scan_ff + IDX_W'(1);
            if (free_here) begin
               mem.ident_we       = 1'b1;
               mem.count_we       = 1'b1;
               mem.wr_addr        = scan_ff;
               mem.ident_wdata    = req_ff.ident;
               valid_in[scan_ff]  = 1'b1;
               res_in.result_slot = SLOT_W'(scan_ff);
            end else if (scan_last) begin
               res_in.status = STS_FULL;
            end
         end
         S_FETCH: begin
            if (req_ff.cmd == CMD_INCR) begin
               mem.count_we       = 1'b1;
               mem.wr_addr        = held_idx;
               mem.count_wdata    = count_next;
               res_in.entry_count = count_next;
            end else begin
               res_in.entry_ident = ident_rdata;
               res_in.entry_count = count_rdata;
               res_in.entry_valid = valid_ff[held_idx];
            end
         end
         S_CLR_CNT: begin
            scan_in = scan_ff + IDX_W'(1);
            if (valid_ff[scan_ff]) begin
               mem.count_we = 1'b1;
               mem.wr_addr  = scan_ff;
            end
         end
         S_DONE: res_valid = 1'b1;
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_INIT;
         scan_ff    <= '0;
         chk_vld_ff <= 1'b0;
         valid_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         scan_ff    <= scan_in;
         chk_vld_ff <= chk_vld_in;
         valid_ff   <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      res_ff     <= res_in;
      chk_idx_ff <= chk_idx_in;
   end

   assign res = res_ff;

   // identifiers are only written by the reset sweep or by create
   a_ident_write: assert property (@(posedge clock) disable iff (reset)
      mem.ident_we |-> (state_ff == S_INIT || state_ff == S_CREATE))
      else $error("identifier written outside sweep or create");

   // a successful create marks its slot valid
   a_create_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CREATE && free_here) |=> valid_ff[$past(scan_ff)])
      else $error("created slot not marked valid");

   // a lookup hit always names a valid entry
   a_lookup_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && req_ff.cmd == CMD_LOOKUP && res_ff.status == STS_OK)
      |-> valid_ff[res_ff.result_slot[IDX_W-1:0]])
      else $error("lookup hit on invalid entry");

   // no item is taken while a result is being handed over
   a_ready_done: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !res_valid)
      else $error("item accepted while result pending");

endmodule

[design/uid_counter_table.sv]
// ----------------------------------------------------------------------------
// uid_counter_table
// Table of 64 entries (valid bit, 32-bit identifier, 8-bit counter) driven
// by a command stream, one result item per command item.
// ----------------------------------------------------------------------------
// Commands run one at a time. Lookup walks the identifier memory one entry per
// cycle through its single read port and stops early on a hit; create scans
// the valid bits for the first free slot; clear counts sweeps every entry;
// increment and read entry of an in-range slot wait in a fetch state for the
// registered memory read; write count, clear all and the unused code go
// straight to the result. The next item is accepted as soon as the result is
// in the output register. After reset the block zeroes both memories in one
// pass over all entries with req_tready low.
module uid_counter_table (
   input  logic        clock,
   input  logic        reset,
   // command item: command[2:0], ident[34:3], slot[42:35], count_value[50:43]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,
   // result item: status[1:0], result_slot[9:2], entry_ident[41:10],
   // entry_count[49:42], entry_valid[50]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata
);
   import uct_pkg::*;

   uct_req_type     req;
   uct_mem_req_type mem;
   uct_rsp_type     res;
   logic            res_valid;
   logic            res_ready;
   logic [ID_W-1:0]  ident_rdata;
   logic [CNT_W-1:0] count_rdata;

   logic            rsp_valid_ff;
   uct_rsp_type     rsp_data_ff;

   // unpack command item
   assign req.cmd         = uct_cmd_type'(req_tdata[2:0]);
   assign req.ident       = req_tdata[34:3];
   assign req.slot        = req_tdata[42:35];
   assign req.count_value = req_tdata[50:43];

   uct_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req         (req),
      .req_ready   (req_tready),
      .mem         (mem),
      .ident_rdata (ident_rdata),
      .count_rdata (count_rdata),
      .res_valid   (res_valid),
      .res         (res),
      .res_ready   (res_ready)
   );

   uct_ram #(.WIDTH(ID_W), .DEPTH(ENTRIES), .AW(IDX_W)) u_ident_ram (
      .clock   (clock),
      .wr_en   (mem.ident_we),
      .wr_addr (mem.wr_addr),
      .wr_data (mem.ident_wdata),
      .rd_addr (mem.ident_raddr),
      .rd_data (ident_rdata)
   );

   uct_ram #(.WIDTH(CNT_W), .DEPTH(ENTRIES), .AW(IDX_W)) u_count_ram (
      .clock   (clock),
      .wr_en   (mem.count_we),
      .wr_addr (mem.wr_addr),
      .wr_data (mem.count_wdata),
      .rd_addr (mem.count_raddr),
      .rd_data (count_rdata)
   );

   // output register
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_data_ff <= res;
      end
   end

   // pack result item
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0,
                        rsp_data_ff.entry_valid,
                        rsp_data_ff.entry_count,
                        rsp_data_ff.entry_ident,
                        rsp_data_ff.result_slot,
                        rsp_data_ff.status};

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives command items into the identifier counter table and checks every
// result item against a behavioral copy of the table kept in the bench.
// Directed tests cover empty, duplicate, saturating, out-of-range and
// full-table cases. Random traffic then runs with idling on both sides and
// with a long output stall.
// ----------------------------------------------------------------------------
module testbench;
   import uct_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 100;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;

   // bench copy of the table contents
   logic [ENTRIES-1:0] tbl_valid;
   logic [ID_W-1:0]    tbl_ident [ENTRIES];
   logic [CNT_W-1:0]   tbl_count [ENTRIES];

   uct_rsp_type        pending_results [$];
   logic [ID_W-1:0]    ident_pool [16];

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int          hold_cycles   = 0;
   int          fail_count    = 0;
   int          quiet_cycles  = 0;

   uid_counter_table DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // table behavior: returns the result of one command and updates the copy
   function automatic uct_rsp_type table_response(input uct_req_type r);
      uct_rsp_type res;
      res = '0;
      res.status = STS_OK;
      case (r.cmd)
         CMD_LOOKUP: begin
            res.status = STS_NOT_FOUND;
            for (int i = 0; i < ENTRIES; i++) begin
               if (res.status == STS_NOT_FOUND && tbl_valid[i] && tbl_ident[i] == r.ident) begin
                  res.status = STS_OK;
                  res.result_slot = SLOT_W'(i);
               end
            end
         end
         CMD_CREATE: begin
            res.status = STS_FULL;
            for (int i = 0; i < ENTRIES; i++) begin
               if (res.status == STS_FULL && !tbl_valid[i]) begin
                  tbl_valid[i] = 1'b1;
                  tbl_ident[i] = r.ident;
                  tbl_count[i] = '0;
                  res.status = STS_OK;
                  res.result_slot = SLOT_W'(i);
               end
            end
         end
         CMD_INCR: begin
            if (r.slot >= ENTRIES) begin
               res.status = STS_RANGE;
            end else begin
               if (tbl_count[r.slot] != COUNT_MAX)
                  tbl_count[r.slot] = tbl_count[r.slot] + 1'b1;
               res.entry_count = tbl_count[r.slot];
            end
         end
         CMD_WRITE: begin
            if (r.slot >= ENTRIES)
               res.status = STS_RANGE;
            else
               tbl_count[r.slot] = r.count_value;
         end
         CMD_READ: begin
            if (r.slot >= ENTRIES) begin
               res.status = STS_RANGE;
            end else begin
               res.entry_ident = tbl_ident[r.slot];
               res.entry_count = tbl_count[r.slot];
               res.entry_valid = tbl_valid[r.slot];
            end
         end
         CMD_CLR_CNT: begin
            for (int i = 0; i < ENTRIES; i++)
               if (tbl_valid[i])
                  tbl_count[i] = '0;
         end
         CMD_CLR_ALL: begin
            tbl_valid = '0;
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   // offer one command item, with random idle cycles first
   task automatic send_cmd(input uct_cmd_type cmd, input logic [ID_W-1:0] ident,
                           input logic [SLOT_W-1:0] slot, input logic [CNT_W-1:0] value);
      uct_req_type r;
      r.cmd = cmd;
      r.ident = ident;
      r.slot = slot;
      r.count_value = value;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, value, slot, ident, cmd};
      do
         @(posedge clock);
      while (!req_tready);
      pending_results.push_back(table_response(r));
   endtask

   // lower valid once the stream pauses
   task automatic end_stream;
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // receiver: random stalls, or a long hold-off when requested
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // compare each result item with the oldest expected one
   always @(posedge clock) begin : rsp_check
      uct_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result item with none expected, actual %h", $time, rsp_tdata);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_tdata[1:0]));
            check_field("result_slot", 32'(want.result_slot), 32'(rsp_tdata[9:2]));
            check_field("entry_ident", want.entry_ident, rsp_tdata[41:10]);
            check_field("entry_count", 32'(want.entry_count), 32'(rsp_tdata[49:42]));
            check_field("entry_valid", 32'(want.entry_valid), 32'(rsp_tdata[50]));
         end
      end
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // empty table after reset, basic create, lookup, clear and unused code
   task automatic test_basic_ops;
      send_cmd(CMD_LOOKUP, 32'h0, 8'd0, 8'd0);          // ident 0 must miss on empty table
      send_cmd(CMD_READ, 32'h0, 8'd0, 8'd0);
      send_cmd(CMD_READ, 32'hFFFF_FFFF, 8'(LAST_IDX), 8'hFF);
      send_cmd(CMD_CREATE, 32'hFFFF_FFFF, 8'd0, 8'd0);
      send_cmd(CMD_CREATE, 32'h0, 8'hFF, 8'hFF);
      send_cmd(CMD_CREATE, 32'hFFFF_FFFF, 8'd0, 8'd0);  // duplicate is accepted
      send_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 8'd0, 8'd0);  // lowest copy wins
      send_cmd(CMD_LOOKUP, 32'h0, 8'd0, 8'd0);
      send_cmd(CMD_LOOKUP, 32'h1234_5678, 8'd0, 8'd0);
      send_cmd(CMD_INCR, 32'h0, 8'd40, 8'd0);           // counter of a free slot
      send_cmd(CMD_READ, 32'h0, 8'd40, 8'd0);
      send_cmd(CMD_WRITE, 32'h0, 8'd1, 8'd200);
      send_cmd(CMD_CLR_CNT, 32'h0, 8'd0, 8'd0);
      send_cmd(CMD_READ, 32'h0, 8'd1, 8'd0);
      send_cmd(CMD_READ, 32'h0, 8'd40, 8'd0);           // free slot keeps its counter
      send_cmd(CMD_NOP, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
      send_cmd(CMD_CLR_ALL, 32'h0, 8'd0, 8'd0);
      send_cmd(CMD_LOOKUP, 32'h0, 8'd0, 8'd0);
      send_cmd(CMD_READ, 32'h0, 8'd0, 8'd0);            // ident survives clear all
      send_cmd(CMD_CREATE, 32'hA5A5_A5A5, 8'd0, 8'd0);
      send_cmd(CMD_READ, 32'h0, 8'd0, 8'd0);
      end_stream();
   endtask

   // counter stops at its maximum
   task automatic test_saturation;
      send_cmd(CMD_WRITE, 32'h0, 8'd5, 8'd254);
      send_cmd(CMD_INCR, 32'h0, 8'd5, 8'd0);
      send_cmd(CMD_INCR, 32'h0, 8'd5, 8'd0);
      send_cmd(CMD_READ, 32'h0, 8'd5, 8'd0);
      send_cmd(CMD_WRITE, 32'h0, 8'(LAST_IDX), 8'hFF);
      send_cmd(CMD_INCR, 32'h0, 8'(LAST_IDX), 8'h0);
      end_stream();
   endtask

   // slot indexes past the last entry
   task automatic test_range;
      send_cmd(CMD_INCR, 32'h0, 8'(ENTRIES), 8'd0);
      send_cmd(CMD_WRITE, 32'h0, 8'(ENTRIES), 8'd77);
      send_cmd(CMD_READ, 32'h0, 8'(ENTRIES), 8'd0);
      send_cmd(CMD_READ, 32'h0, 8'hFF, 8'd0);
      send_cmd(CMD_WRITE, 32'h0, 8'hFF, 8'hFF);
      send_cmd(CMD_INCR, 32'h0, 8'h80, 8'd0);
      send_cmd(CMD_READ, 32'h0, 8'(ENTRIES), 8'd0);
      end_stream();
   endtask

   // fill every slot, overflow, then deep lookups
   task automatic test_fill_table;
      logic [ID_W-1:0] deep_ident;
      send_cmd(CMD_CLR_ALL, 32'h0, 8'd0, 8'd0);
      for (int i = 0; i < ENTRIES; i++) begin
         deep_ident = $urandom();
         send_cmd(CMD_CREATE, deep_ident, 8'($urandom_range(255)), 8'($urandom_range(255)));
      end
      send_cmd(CMD_CREATE, 32'hDEAD_0001, 8'd0, 8'd0);
      send_cmd(CMD_LOOKUP, deep_ident, 8'd0, 8'd0);
      send_cmd(CMD_LOOKUP, 32'hDEAD_0001, 8'd0, 8'd0);
      send_cmd(CMD_READ, 32'h0, 8'(LAST_IDX), 8'd0);
      send_cmd(CMD_CLR_CNT, 32'h0, 8'd0, 8'd0);
      send_cmd(CMD_CLR_ALL, 32'h0, 8'd0, 8'd0);
      send_cmd(CMD_CREATE, 32'hDEAD_0002, 8'd0, 8'd0);
      end_stream();
   endtask

   // random commands, mostly on identifiers and slots in use
   task automatic test_random(input int n_items, input int unsigned send_pct,
                              input int unsigned recv_pct);
      int unsigned     pick;
      uct_cmd_type     cmd;
      logic [ID_W-1:0] ident;
      logic [SLOT_W-1:0] slot;
      logic [CNT_W-1:0]  value;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int n = 0; n < n_items; n++) begin
         pick = $urandom_range(99);
         if (pick < 30)      cmd = CMD_LOOKUP;
         else if (pick < 52) cmd = CMD_CREATE;
         else if (pick < 70) cmd = CMD_INCR;
         else if (pick < 80) cmd = CMD_WRITE;
         else if (pick < 92) cmd = CMD_READ;
         else if (pick < 95) cmd = CMD_CLR_CNT;
         else if (pick < 96) cmd = CMD_CLR_ALL;
         else                cmd = CMD_NOP;
         ident = ($urandom_range(3) != 0) ? ident_pool[$urandom_range(15)] : $urandom();
         pick = $urandom_range(99);
         if (pick < 60)      slot = 8'($urandom_range(LAST_IDX));
         else if (pick < 85) slot = 8'($urandom_range(7));
         else                slot = 8'($urandom_range(255));
         value = ($urandom_range(3) == 0) ? 8'(253 + $urandom_range(2))
                                          : 8'($urandom_range(255));
         send_cmd(cmd, ident, slot, value);
      end
      end_stream();
   endtask

   // long output stall while the sender keeps offering items
   task automatic test_backpressure;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_cycles = 400;
      for (int n = 0; n < 20; n++)
         send_cmd(uct_cmd_type'($urandom_range(6)), ident_pool[$urandom_range(15)],
                  8'($urandom_range(LAST_IDX)), 8'($urandom_range(255)));
      hold_cycles = 300;
      for (int n = 0; n < 20; n++)
         send_cmd(n[0] ? CMD_READ : CMD_INCR, 32'h0, 8'($urandom_range(7)), 8'd0);
      end_stream();
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      tbl_valid = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         tbl_ident[i] = '0;
         tbl_count[i] = '0;
      end
      for (int i = 0; i < 16; i++)
         ident_pool[i] = $urandom();
      ident_pool[0] = 32'h0;
      ident_pool[1] = 32'hFFFF_FFFF;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_ops();
      test_saturation();
      test_range();
      test_fill_table();
      test_random(400, 32, 57);
      test_random(400, 57, 32);
      test_random(400, 0, 0);
      test_backpressure();

      while (pending_results.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
